>>> rtl/sod_pkg.sv
// Shared constants, types and helper functions for the degree sine pipeline.
`timescale 1ns / 1ps
`default_nettype none
package sod_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int SERIES_PAIRS    = 5;
    localparam int NUM_TERMS       = 2 * SERIES_PAIRS;

    // Degree to radian factor in Q36.
    localparam logic [30:0] DEG2RAD_Q36 = 31'd1199381129;

    localparam int ACC_W = 35;

    // Context that travels with one angle through the series stages.
    typedef struct packed {
        logic                    use_cos;
        logic                    neg;
        logic [31:0]             sq;
        logic signed [ACC_W-1:0] acc;
    } ctx_t;

    // Divisor n*(n+1) of series term j; the sine uses n = 2j+2, the cosine n = 2j+1.
    function automatic int term_div(input int j, input int use_cos);
        int n;
        n = (use_cos != 0) ? (2 * j + 1) : (2 * j + 2);
        return n * (n + 1);
    endfunction

endpackage
`default_nettype wire

>>> rtl/sine_of_degrees_core.sv
// Pipelined sine of a fixed-point angle in degrees, one transaction per cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none
// sine_of_degrees_core takes a signed angle in degrees (Q16.16) and returns its
// sine in signed Q1.30. It accepts one transaction per clock while the output is
// not stalled and returns the results in order. The pipeline is made of an input
// register, the compare-subtract steps of the modulo-360 reduction (NRED = 8
// with the default settings), the fold, radian and squaring stages, three stages
// per series term (multiply, reciprocal multiply, remainder correction and
// accumulate) and an output register. The whole pipeline holds while a finished result waits.
module sine_of_degrees_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] angle_deg
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] sine_value
);
    import sod_pkg::*;

    localparam int F       = ANGLE_FRAC_BITS;
    localparam int UW      = 34;
    localparam int RW      = F + 9;
    localparam int TW      = F + 7;
    localparam int PW      = TW + 31;
    localparam longint FULL_L = longint'(360) << F;
    localparam int NRED    = $clog2(((64'd1 << 31) + FULL_L - 1) / FULL_L) + 1;
    localparam logic [UW-1:0] OFFSET = UW'(FULL_L << (NRED - 1));
    localparam logic [RW-1:0] FULL_R  = RW'(FULL_L);
    localparam logic [RW-1:0] RIGHT   = RW'(longint'(90) << F);
    localparam logic [RW-1:0] STRAIGHT = RW'(longint'(180) << F);
    localparam logic [RW-1:0] THREE_Q = RW'(longint'(270) << F);
    localparam logic [RW-1:0] HALF_R  = RW'(longint'(45) << F);
    localparam logic [31:0]   ONE_Q30 = 32'd1 << 30;
    localparam int LAT = 1 + NRED + 5 + 3 * NUM_TERMS + 1;

    logic [LAT-1:0] valid_reg;
    logic           en;

    assign en            = !valid_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // Modulo 360: an offset makes the angle positive, then compare-subtract steps.
    logic [UW-1:0] red_reg [NRED+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg[0] <= UW'(signed'(s_axis_tdata)) + OFFSET;
        end
    end

    for (genvar i = 0; i < NRED; i++)
    begin : g_red
        localparam logic [UW-1:0] SUB = UW'(FULL_L << (NRED - 1 - i));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                red_reg[i+1] <= (red_reg[i] >= SUB) ? (red_reg[i] - SUB) : red_reg[i];
            end
        end
    end

    // Quadrant fold and choice of series.
    logic [RW-1:0] r_c;
    logic [RW-1:0] fold_c;
    logic          neg_c;
    logic [TW-1:0] t_next;
    logic          cos_next;

    always_comb
    begin
        r_c   = red_reg[NRED][RW-1:0];
        neg_c = 1'b0;
        if (r_c < RIGHT)
        begin
            fold_c = r_c;
        end
        else if (r_c < STRAIGHT)
        begin
            fold_c = STRAIGHT - r_c;
        end
        else if (r_c < THREE_Q)
        begin
            fold_c = r_c - STRAIGHT;
            neg_c  = 1'b1;
        end
        else
        begin
            fold_c = FULL_R - r_c;
            neg_c  = 1'b1;
        end
        if (fold_c < HALF_R)
        begin
            t_next   = TW'(fold_c);
            cos_next = 1'b0;
        end
        else
        begin
            t_next   = TW'(RIGHT - fold_c);
            cos_next = 1'b1;
        end
    end

    logic [TW-1:0] t_reg;
    logic [PW-1:0] p_reg;
    logic [31:0]   rad_reg;
    logic [63:0]   rr_reg;
    logic [3:0]    cos_p_reg;
    logic [3:0]    neg_p_reg;
    logic [31:0]   rad2_reg;
    ctx_t          ctx0_reg;
    logic [31:0]   m0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg        <= t_next;
            cos_p_reg[0] <= cos_next;
            neg_p_reg[0] <= neg_c;
            p_reg        <= PW'(t_reg) * PW'(DEG2RAD_Q36);
            rad_reg      <= 32'((p_reg + (PW'(1) << (F + 5))) >> (F + 6));
            rr_reg       <= 64'(rad_reg) * 64'(rad_reg);
            rad2_reg     <= rad_reg;
            cos_p_reg[3:1] <= cos_p_reg[2:0];
            neg_p_reg[3:1] <= neg_p_reg[2:0];
            ctx0_reg.use_cos <= cos_p_reg[3];
            ctx0_reg.neg     <= neg_p_reg[3];
            ctx0_reg.sq      <= 32'((rr_reg + (64'd1 << 29)) >> 30);
            m0_reg           <= cos_p_reg[3] ? ONE_Q30 : rad2_reg;
            ctx0_reg.acc     <= cos_p_reg[3] ? ACC_W'(ONE_Q30) : ACC_W'(rad2_reg);
        end
    end

    // Series terms, three stages each.
    ctx_t        ctx_a_reg [NUM_TERMS];
    logic [63:0] prod_a_reg [NUM_TERMS];
    ctx_t        ctx_b_reg [NUM_TERMS];
    logic [31:0] p_b_reg [NUM_TERMS];
    logic [63:0] prod_b_reg [NUM_TERMS];
    ctx_t        ctx_c_reg [NUM_TERMS];
    logic [31:0] m_c_reg [NUM_TERMS];

    for (genvar j = 0; j < NUM_TERMS; j++)
    begin : g_term
        localparam int     D_SIN = term_div(j, 0);
        localparam int     D_COS = term_div(j, 1);
        localparam longint R_SIN = (64'd1 << 32) / D_SIN;
        localparam longint R_COS = (64'd1 << 32) / D_COS;

        ctx_t        ctx_in;
        logic [31:0] m_in;
        logic [31:0] p_a;
        logic [31:0] recip;
        logic [10:0] div_c;
        logic [31:0] q0;
        logic [43:0] rem;
        logic [31:0] q;

        if (j == 0)
        begin : g_first
            assign ctx_in = ctx0_reg;
            assign m_in   = m0_reg;
        end
        else
        begin : g_next
            assign ctx_in = ctx_c_reg[j-1];
            assign m_in   = m_c_reg[j-1];
        end

        assign p_a   = prod_a_reg[j][61:30];
        assign recip = ctx_a_reg[j].use_cos ? 32'(R_COS) : 32'(R_SIN);
        assign div_c = ctx_b_reg[j].use_cos ? 11'(D_COS) : 11'(D_SIN);
        assign q0    = prod_b_reg[j][63:32];
        assign rem   = 44'(p_b_reg[j]) - 44'(q0) * 44'(div_c);
        assign q     = q0 + 32'(rem >= 44'(div_c));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctx_a_reg[j]  <= ctx_in;
                prod_a_reg[j] <= 64'(m_in) * 64'(ctx_in.sq);
                ctx_b_reg[j]  <= ctx_a_reg[j];
                p_b_reg[j]    <= p_a;
                prod_b_reg[j] <= 64'(p_a) * 64'(recip);
                ctx_c_reg[j].use_cos <= ctx_b_reg[j].use_cos;
                ctx_c_reg[j].neg     <= ctx_b_reg[j].neg;
                ctx_c_reg[j].sq      <= ctx_b_reg[j].sq;
                m_c_reg[j]    <= q;
                // Each pair subtracts its first term and adds its second.
                if ((j % 2) == 0)
                begin
                    ctx_c_reg[j].acc <= ctx_b_reg[j].acc - signed'(ACC_W'(q));
                end
                else
                begin
                    ctx_c_reg[j].acc <= ctx_b_reg[j].acc + signed'(ACC_W'(q));
                end
            end
        end
    end

    // Clamp to [0, 1.0] and apply the quadrant sign.
    ctx_t        last_c;
    logic [31:0] clamp_c;
    logic [31:0] out_reg;

    assign last_c = ctx_c_reg[NUM_TERMS-1];

    always_comb
    begin
        if (last_c.acc < 0)
        begin
            clamp_c = '0;
        end
        else if (last_c.acc > signed'(ACC_W'(ONE_Q30)))
        begin
            clamp_c = ONE_Q30;
        end
        else
        begin
            clamp_c = last_c.acc[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= last_c.neg ? (32'd0 - clamp_c) : clamp_c;
        end
    end

    assign m_axis_tdata = out_reg;

endmodule
`default_nettype wire

>>> rtl/sod_checker.sv
// Port-level checks for the degree sine pipeline and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
module sod_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [31:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // The input side only stalls when the output side does.
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output was free");

    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata) <= 32'sd1073741824 &&
                           $signed(m_axis_tdata) >= -32'sd1073741824))
        else $error("sine value out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid |-> !$isunknown(s_axis_tdata))
        else $error("input angle has unknown bits");

endmodule

bind sine_of_degrees_core sod_checker u_sod_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
